FILE: rtl/sensor_frame_statistics_defines.svh
// Assertion macros used by the sensor frame statistics RTL.
`ifndef SENSOR_FRAME_STATISTICS_DEFINES_SVH
`define SENSOR_FRAME_STATISTICS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sensor_frame_statistics: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sensor_frame_statistics: check failed");

`endif

FILE: rtl/sfs_pkg.sv
// Shared types and constants of the sensor frame statistics block.
`default_nettype none

package sfs_pkg;

  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned MAX_SAMPLES_DEF = 256;
  localparam int unsigned LEVEL_W         = 15;
  localparam int unsigned COUNT_OUT_W     = 9;
  localparam int unsigned INDEX_OUT_W     = 8;
  localparam int unsigned ALU_W_DEF       = LEVEL_W + $clog2(MAX_SAMPLES_DEF + 1);
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN = 2'd2;

  localparam logic [LEVEL_W-1:0] WARNING_RESET  = 15'd480;
  localparam logic [LEVEL_W-1:0] CRITICAL_RESET = 15'd720;
  localparam logic [LEVEL_W-1:0] SHUTDOWN_RESET = 15'd960;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] total_count;
    logic [COUNT_OUT_W-1:0] error_count;
    logic [LEVEL_W-1:0]     min_value;
    logic [LEVEL_W-1:0]     max_value;
    logic [LEVEL_W-1:0]     mean_value;
    logic                   any_valid;
    logic                   critical_seen;
    logic [INDEX_OUT_W-1:0] first_critical_index;
    logic [COUNT_OUT_W-1:0] normal_count;
    logic [COUNT_OUT_W-1:0] warning_count;
    logic [COUNT_OUT_W-1:0] critical_count;
    logic [COUNT_OUT_W-1:0] shutdown_count;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/sfs_alu.sv
// Shared add, subtract and compare unit of the statistics sequencer.
`default_nettype none

module sfs_alu
  import sfs_pkg::*;
#(
  parameter int unsigned W = ALU_W_DEF
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         lt_o
);

  logic [W-1:0] b_eff;
  logic [W:0]   sum;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum   = {1'b0, a_i} + {1'b0, b_eff} + (W + 1)'(sub_i);
  assign res_o = sum[W-1:0];
  assign lt_o  = sub_i & ~sum[W];

endmodule

`default_nettype wire

FILE: rtl/sfs_out_stage.sv
// Output register that holds one frame summary until it is transferred.
`default_nettype none

module sfs_out_stage
  import sfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t data_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/sensor_frame_statistics.sv
// Per-frame sensor statistics: min, max, mean, error count and threshold bins.
// A valid sample passes TAKE, MIN, MAX, WARN, CRIT, SHUT and SUM before the next ready, a
// negative or ignored sample TAKE only; the shared adder does six steps for a valid sample.
// After the last sample of a frame come the valid count, a divide over ALU_W bits (ALU_W =
// 15 + clog2(MAX_SAMPLES+1), 24 by default) if any sample was valid, and any output stall.
// Reset is asynchronous, active low: thresholds return to 480/720/960, frame state clears.
`default_nettype none
`include "sensor_frame_statistics_defines.svh"

module sensor_frame_statistics
  import sfs_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned PIDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned SUM_W  = LEVEL_W + CNT_W;
  localparam int unsigned DIV_W  = $clog2(SUM_W);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TAKE = 4'd1;
  localparam logic [3:0] S_MIN  = 4'd2;
  localparam logic [3:0] S_MAX  = 4'd3;
  localparam logic [3:0] S_WARN = 4'd4;
  localparam logic [3:0] S_CRIT = 4'd5;
  localparam logic [3:0] S_SHUT = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_VCNT = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_LOAD = 4'd10;

  localparam logic [1:0] BIN_NORMAL   = 2'd0;
  localparam logic [1:0] BIN_WARNING  = 2'd1;
  localparam logic [1:0] BIN_CRITICAL = 2'd2;
  localparam logic [1:0] BIN_SHUTDOWN = 2'd3;

  logic [3:0]         state_q, state_d;
  logic [LEVEL_W-1:0] warn_q, warn_d, crit_q, crit_d, shut_q, shut_d;
  logic [CNT_W-1:0]   pos_q, pos_d, err_q, err_d;
  logic [LEVEL_W-1:0] min_q, min_d, max_q, max_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               seen_q, seen_d, crit_seen_q, crit_seen_d;
  logic [PIDX_W-1:0]  crit_pos_q, crit_pos_d;
  logic [CNT_W-1:0]   tally_q [4];
  logic [CNT_W-1:0]   tally_d [4];

  logic [LEVEL_W-1:0] v_q, v_d;
  logic               neg_q, neg_d, end_q, end_d;
  logic               lt_warn_q, lt_warn_d, lt_crit_q, lt_crit_d;
  logic [CNT_W-1:0]   div_q, div_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]   dcnt_q, dcnt_d;

  logic [SUM_W-1:0]   alu_a, alu_b, alu_res, rem_shift;
  logic               alu_sub, alu_lt;
  logic [1:0]         bin_sel;
  logic               out_load, out_free;
  out_item_t          out_item;
  logic [31:0]        pos_x, err_x, crit_x, n_x, w_x, c_x, s_x;
  logic [CNT_W+1:0]   bin_total;

  assign in_ready_o = (state_q == S_IDLE);
  assign rem_shift  = {rem_q[SUM_W-2:0], sum_q[SUM_W-1]};

  sfs_alu #(
    .W (SUM_W)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_q)
      S_MIN: begin
        alu_a = SUM_W'(v_q);
        alu_b = SUM_W'(min_q);
      end
      S_MAX: begin
        alu_a = SUM_W'(max_q);
        alu_b = SUM_W'(v_q);
      end
      S_WARN: begin
        alu_a = SUM_W'(v_q);
        alu_b = SUM_W'(warn_q);
      end
      S_CRIT: begin
        alu_a = SUM_W'(v_q);
        alu_b = SUM_W'(crit_q);
      end
      S_SHUT: begin
        alu_a = SUM_W'(v_q);
        alu_b = SUM_W'(shut_q);
      end
      S_SUM: begin
        alu_a   = sum_q;
        alu_b   = SUM_W'(v_q);
        alu_sub = 1'b0;
      end
      S_VCNT: begin
        alu_a = SUM_W'(pos_q);
        alu_b = SUM_W'(err_q);
      end
      S_DIV: begin
        alu_a = rem_shift;
        alu_b = SUM_W'(div_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    if (lt_warn_q) begin
      bin_sel = BIN_NORMAL;
    end else if (lt_crit_q) begin
      bin_sel = BIN_WARNING;
    end else if (alu_lt) begin
      bin_sel = BIN_CRITICAL;
    end else begin
      bin_sel = BIN_SHUTDOWN;
    end
  end

  always_comb begin
    state_d     = state_q;
    warn_d      = warn_q;
    crit_d      = crit_q;
    shut_d      = shut_q;
    pos_d       = pos_q;
    err_d       = err_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    crit_seen_d = crit_seen_q;
    crit_pos_d  = crit_pos_q;
    tally_d     = tally_q;
    v_d         = v_q;
    neg_d       = neg_q;
    end_d       = end_q;
    lt_warn_d   = lt_warn_q;
    lt_crit_d   = lt_crit_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    out_load    = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WARNING:  warn_d = cfg_data_i;
        REG_CRITICAL: crit_d = cfg_data_i;
        REG_SHUTDOWN: shut_d = cfg_data_i;
        default:      warn_d = warn_q;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          v_d     = in_data_i.sample[LEVEL_W-1:0];
          neg_d   = in_data_i.sample[SAMPLE_BITS-1];
          end_d   = in_data_i.frame_end;
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        if (pos_q >= CNT_W'(MAX_SAMPLES)) begin
          state_d = end_q ? S_VCNT : S_IDLE;
        end else if (neg_q) begin
          err_d   = err_q + 1'b1;
          pos_d   = pos_q + 1'b1;
          state_d = end_q ? S_VCNT : S_IDLE;
        end else begin
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        if (!seen_q || alu_lt) begin
          min_d = v_q;
        end
        state_d = S_MAX;
      end
      S_MAX: begin
        if (!seen_q || alu_lt) begin
          max_d = v_q;
        end
        seen_d  = 1'b1;
        state_d = S_WARN;
      end
      S_WARN: begin
        lt_warn_d = alu_lt;
        state_d   = S_CRIT;
      end
      S_CRIT: begin
        lt_crit_d = alu_lt;
        if (!alu_lt && !crit_seen_q) begin
          crit_seen_d = 1'b1;
          crit_pos_d  = pos_q[PIDX_W-1:0];
        end
        state_d = S_SHUT;
      end
      S_SHUT: begin
        tally_d[bin_sel] = tally_q[bin_sel] + 1'b1;
        state_d          = S_SUM;
      end
      S_SUM: begin
        sum_d   = alu_res;
        pos_d   = pos_q + 1'b1;
        state_d = end_q ? S_VCNT : S_IDLE;
      end
      S_VCNT: begin
        div_d   = alu_res[CNT_W-1:0];
        rem_d   = '0;
        dcnt_d  = DIV_W'(SUM_W - 1);
        state_d = seen_q ? S_DIV : S_LOAD;
      end
      S_DIV: begin
        rem_d = alu_lt ? rem_shift : alu_res;
        sum_d = {sum_q[SUM_W-2:0], !alu_lt};
        if (dcnt_q == '0) begin
          state_d = S_LOAD;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          out_load    = 1'b1;
          pos_d       = '0;
          err_d       = '0;
          min_d       = '0;
          max_d       = '0;
          sum_d       = '0;
          seen_d      = 1'b0;
          crit_seen_d = 1'b0;
          crit_pos_d  = '0;
          tally_d     = '{default: '0};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      warn_q      <= WARNING_RESET;
      crit_q      <= CRITICAL_RESET;
      shut_q      <= SHUTDOWN_RESET;
      pos_q       <= '0;
      err_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      seen_q      <= 1'b0;
      crit_seen_q <= 1'b0;
      crit_pos_q  <= '0;
      tally_q     <= '{default: '0};
    end else begin
      state_q     <= state_d;
      warn_q      <= warn_d;
      crit_q      <= crit_d;
      shut_q      <= shut_d;
      pos_q       <= pos_d;
      err_q       <= err_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      crit_seen_q <= crit_seen_d;
      crit_pos_q  <= crit_pos_d;
      tally_q     <= tally_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    neg_q     <= neg_d;
    end_q     <= end_d;
    lt_warn_q <= lt_warn_d;
    lt_crit_q <= lt_crit_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
  end

  assign pos_x  = 32'(pos_q);
  assign err_x  = 32'(err_q);
  assign crit_x = 32'(crit_pos_q);
  assign n_x    = 32'(tally_q[BIN_NORMAL]);
  assign w_x    = 32'(tally_q[BIN_WARNING]);
  assign c_x    = 32'(tally_q[BIN_CRITICAL]);
  assign s_x    = 32'(tally_q[BIN_SHUTDOWN]);

  always_comb begin
    out_item.total_count          = pos_x[COUNT_OUT_W-1:0];
    out_item.error_count          = err_x[COUNT_OUT_W-1:0];
    out_item.min_value            = min_q;
    out_item.max_value            = max_q;
    out_item.mean_value           = sum_q[LEVEL_W-1:0];
    out_item.any_valid            = seen_q;
    out_item.critical_seen        = crit_seen_q;
    out_item.first_critical_index = crit_x[INDEX_OUT_W-1:0];
    out_item.normal_count         = n_x[COUNT_OUT_W-1:0];
    out_item.warning_count        = w_x[COUNT_OUT_W-1:0];
    out_item.critical_count       = c_x[COUNT_OUT_W-1:0];
    out_item.shutdown_count       = s_x[COUNT_OUT_W-1:0];
  end

  sfs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .data_i      (out_item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign bin_total = (CNT_W + 2)'(tally_q[BIN_NORMAL]) + (CNT_W + 2)'(tally_q[BIN_WARNING])
                   + (CNT_W + 2)'(tally_q[BIN_CRITICAL]) + (CNT_W + 2)'(tally_q[BIN_SHUTDOWN])
                   + (CNT_W + 2)'(err_q);

  `SFS_ASSERT_IMPLIES(a_min_le_max, clk_i, rst_ni, seen_q && state_q == S_IDLE, min_q <= max_q)
  `SFS_ASSERT_IMPLIES(a_bins_balance, clk_i, rst_ni, state_q == S_IDLE, bin_total == (CNT_W + 2)'(pos_q))
  `SFS_ASSERT_IMPLIES(a_crit_before_pos, clk_i, rst_ni, crit_seen_q && state_q == S_IDLE, CNT_W'(crit_pos_q) < pos_q)
  `SFS_ASSERT_NEXT(a_load_shows_result, clk_i, rst_ni, out_load, out_valid_o && state_q == S_IDLE)

endmodule

`default_nettype wire

FILE: bench/sfs_summary_checker.sv
// Frame summary checker: predicts each frame summary and compares it with the block's output.
`timescale 1ns / 100ps

module sfs_summary_checker
  import sfs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned SUM_W = LEVEL_W + COUNT_OUT_W - 1;

  typedef enum int unsigned {
    ZONE_NORMAL,
    ZONE_WARNING,
    ZONE_CRITICAL,
    ZONE_SHUTDOWN
  } zone_e;

  logic [LEVEL_W-1:0]     warn_lvl;
  logic [LEVEL_W-1:0]     crit_lvl;
  logic [LEVEL_W-1:0]     shut_lvl;
  logic [COUNT_OUT_W-1:0] frame_pos;
  logic [COUNT_OUT_W-1:0] skipped;
  logic [LEVEL_W-1:0]     lo_val;
  logic [LEVEL_W-1:0]     hi_val;
  logic [SUM_W-1:0]       sum_acc;
  logic                   any_valid_q;
  logic                   crit_q;
  logic [INDEX_OUT_W-1:0] crit_pos;
  logic [COUNT_OUT_W-1:0] zone_tally [4];
  out_item_t              expected_summaries [$];
  int unsigned            mismatches = 0;
  int unsigned            summaries_seen = 0;

  task automatic clear_frame();
    frame_pos   = '0;
    skipped     = '0;
    lo_val      = '0;
    hi_val      = '0;
    sum_acc     = '0;
    any_valid_q = 1'b0;
    crit_q      = 1'b0;
    crit_pos    = '0;
    for (int z = 0; z < 4; z++) zone_tally[z] = '0;
  endtask

  task automatic fold_sample(input in_item_t item);
    logic [LEVEL_W-1:0]     v;
    logic [COUNT_OUT_W-1:0] valid_cnt;
    zone_e                  zone;
    out_item_t              summary;
    v = item.sample[LEVEL_W-1:0];
    if (32'(frame_pos) < MAX_SAMPLES_DEF) begin
      if (item.sample[SAMPLE_BITS-1]) begin
        skipped++;
      end else begin
        sum_acc = sum_acc + SUM_W'(v);
        if (!any_valid_q) begin
          lo_val      = v;
          hi_val      = v;
          any_valid_q = 1'b1;
        end else begin
          if (v < lo_val) lo_val = v;
          if (v > hi_val) hi_val = v;
        end
        if (v >= crit_lvl && !crit_q) begin
          crit_q   = 1'b1;
          crit_pos = frame_pos[INDEX_OUT_W-1:0];
        end
        if (v < warn_lvl) zone = ZONE_NORMAL;
        else if (v < crit_lvl) zone = ZONE_WARNING;
        else if (v < shut_lvl) zone = ZONE_CRITICAL;
        else zone = ZONE_SHUTDOWN;
        zone_tally[zone]++;
      end
      frame_pos++;
    end
    if (item.frame_end) begin
      valid_cnt                    = frame_pos - skipped;
      summary.total_count          = frame_pos;
      summary.error_count          = skipped;
      summary.min_value            = any_valid_q ? lo_val : '0;
      summary.max_value            = any_valid_q ? hi_val : '0;
      summary.mean_value           = (any_valid_q && valid_cnt != 0) ?
                                     LEVEL_W'(sum_acc / SUM_W'(valid_cnt)) : '0;
      summary.any_valid            = any_valid_q;
      summary.critical_seen        = crit_q;
      summary.first_critical_index = crit_q ? crit_pos : '0;
      summary.normal_count         = zone_tally[ZONE_NORMAL];
      summary.warning_count        = zone_tally[ZONE_WARNING];
      summary.critical_count       = zone_tally[ZONE_CRITICAL];
      summary.shutdown_count       = zone_tally[ZONE_SHUTDOWN];
      expected_summaries.push_back(summary);
      clear_frame();
    end
  endtask

  task automatic note_failure(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      note_failure($sformatf("summary %0d: %s expected %0d, got %0d",
                             summaries_seen, name, want, got));
    end
  endtask

  task automatic check_summary(input out_item_t got);
    out_item_t want;
    if (expected_summaries.size() == 0) begin
      note_failure($sformatf("summary %0d arrived with none expected", summaries_seen));
    end else begin
      want = expected_summaries.pop_front();
      compare_field("total_count", want.total_count, got.total_count);
      compare_field("error_count", want.error_count, got.error_count);
      compare_field("min_value", want.min_value, got.min_value);
      compare_field("max_value", want.max_value, got.max_value);
      compare_field("mean_value", want.mean_value, got.mean_value);
      compare_field("any_valid", want.any_valid, got.any_valid);
      compare_field("critical_seen", want.critical_seen, got.critical_seen);
      compare_field("first_critical_index", want.first_critical_index,
                    got.first_critical_index);
      compare_field("normal_count", want.normal_count, got.normal_count);
      compare_field("warning_count", want.warning_count, got.warning_count);
      compare_field("critical_count", want.critical_count, got.critical_count);
      compare_field("shutdown_count", want.shutdown_count, got.shutdown_count);
    end
    summaries_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_lvl = WARNING_RESET;
      crit_lvl = CRITICAL_RESET;
      shut_lvl = SHUTDOWN_RESET;
      clear_frame();
      expected_summaries.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WARNING: begin
            warn_lvl = cfg_data_i;
          end
          REG_CRITICAL: begin
            crit_lvl = cfg_data_i;
          end
          REG_SHUTDOWN: begin
            shut_lvl = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) fold_sample(in_data_i);
      if (out_valid_i && out_ready_i) check_summary(out_data_i);
      fail_count_o <= mismatches;
      pending_o    <= expected_summaries.size();
    end
  end

endmodule

FILE: bench/tb_sensor_frame_statistics.sv
// Top of the sensor frame statistics testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sensor_frame_statistics;
  import sfs_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 33;

  typedef enum int unsigned {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH
  } flow_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [LEVEL_W-1:0]   cfg_data  = '0;
  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          idle_pct  = 0;
  int unsigned          stall_pct = 0;
  logic [LEVEL_W-1:0]   warn_lvl  = WARNING_RESET;
  logic [LEVEL_W-1:0]   crit_lvl  = CRITICAL_RESET;
  logic [LEVEL_W-1:0]   shut_lvl  = SHUTDOWN_RESET;

  sensor_frame_statistics i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  sfs_summary_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_flow(input flow_e flow);
    case (flow)
      FLOW_FREE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      FLOW_SENDER_IDLE: begin
        idle_pct  = 63;
        stall_pct = 0;
      end
      FLOW_SINK_STALL: begin
        idle_pct  = 0;
        stall_pct = 63;
      end
      default: begin
        idle_pct  = 23;
        stall_pct = 23;
      end
    endcase
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.sample    <= value;
    in_data.frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned roll;
    int          level;
    int          near;
    roll = $urandom_range(99);
    if (roll < 12) return {1'b1, 15'($urandom)};
    if (roll < 20) return '0;
    if (roll < 26) return 16'h7FFF;
    if (roll < 60) begin
      case ($urandom_range(2))
        0: level = int'(warn_lvl);
        1: level = int'(crit_lvl);
        default: level = int'(shut_lvl);
      endcase
      near = level + int'($urandom_range(4)) - 2;
      if (near < 0) near = 0;
      if (near > 32767) near = 32767;
      return {1'b0, 15'(near)};
    end
    return {1'b0, 15'($urandom)};
  endfunction

  task automatic send_random_frames(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 15) len = 1;
      else if (roll < 85) len = $urandom_range(12, 2);
      else len = $urandom_range(40, 13);
      for (int unsigned i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
      sent += len;
    end
  endtask

  // Runs past the sample limit, with a first critical reading late in the frame
  // and another one among the ignored samples.
  task automatic send_overlong_frame();
    int unsigned             len;
    int unsigned             crit_at;
    logic [SAMPLE_BITS-1:0]  value;
    len     = $urandom_range(266, 258);
    crit_at = $urandom_range(255, 128);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == len - 2) value = 16'h7FFF;
      else if (i == crit_at) value = {1'b0, 15'($urandom_range(32767, crit_lvl))};
      else if ($urandom_range(9) == 0) value = {1'b1, 15'($urandom)};
      else value = {1'b0, 15'($urandom_range(int'(crit_lvl) - 1, 0))};
      send_sample(value, i == len - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_levels(input logic [LEVEL_W-1:0] warn, input logic [LEVEL_W-1:0] crit,
                                input logic [LEVEL_W-1:0] shut);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_WARNING;
    cfg_data <= warn;
    @(posedge clk);
    cfg_idx  <= REG_CRITICAL;
    cfg_data <= crit;
    @(posedge clk);
    cfg_idx  <= REG_SHUTDOWN;
    cfg_data <= shut;
    @(posedge clk);
    cfg_we   <= 1'b0;
    warn_lvl = warn;
    crit_lvl = crit;
    shut_lvl = shut;
  endtask

  task automatic run_phase(input logic [LEVEL_W-1:0] warn, input logic [LEVEL_W-1:0] crit,
                           input logic [LEVEL_W-1:0] shut, input flow_e flow);
    program_levels(warn, crit, shut);
    set_flow(flow);
    send_random_frames(PHASE_ITEMS);
  endtask

  initial begin
    int unsigned base;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_flow(FLOW_FREE);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'd479, 1'b0);
    send_sample(16'd480, 1'b0);
    send_sample(16'd719, 1'b0);
    send_sample(16'd720, 1'b0);
    send_sample(16'd959, 1'b0);
    send_sample(16'd960, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd100, 1'b0);
    send_sample(16'd200, 1'b1);
    send_sample(16'd1, 1'b0);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'h2AAA, 1'b1);

    program_levels(WARNING_RESET, CRITICAL_RESET, SHUTDOWN_RESET);
    set_flow(FLOW_SENDER_IDLE);
    send_overlong_frame();
    send_random_frames(PHASE_ITEMS);

    run_phase(15'd0, 15'd0, 15'd0, FLOW_SINK_STALL);
    run_phase(15'h7FFF, 15'h7FFF, 15'h7FFF, FLOW_BOTH);
    run_phase(15'd900, 15'd300, 15'd100, FLOW_FREE);
    run_phase(15'd1, 15'd2, 15'd3, FLOW_SENDER_IDLE);
    for (int k = 0; k < 3; k++) begin
      run_phase(15'($urandom), 15'($urandom), 15'($urandom), flow_e'((k + 2) % 4));
    end
    base = $urandom_range(2000);
    run_phase(15'(base), 15'(base + 600), 15'(base + 600 + $urandom_range(600)),
              FLOW_SENDER_IDLE);

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sfs_alu.sv
rtl/sfs_out_stage.sv
rtl/sensor_frame_statistics.sv
bench/sfs_summary_checker.sv
bench/tb_sensor_frame_statistics.sv
